// ===== sv/rtn_pkg.sv =====
// ----------------------------------------------------------------------------
// rtn_pkg
// shared types, constants and letter tables for the roman numeral converter
// ----------------------------------------------------------------------------
`default_nettype none

package rtn_pkg;

  localparam int VALUE_W       = 14;
  localparam int LETTER_W      = 7;
  localparam int S_TDATA_W     = 16;
  localparam int M_TDATA_W     = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // divide by ten through a reciprocal multiply, exact for operands below 2^14
  localparam logic [14:0] DIV10_MUL   = 15'd26215;
  localparam int          DIV10_SHIFT = 18;

  localparam logic [LETTER_W-1:0] CH_I = 7'h49;
  localparam logic [LETTER_W-1:0] CH_V = 7'h56;
  localparam logic [LETTER_W-1:0] CH_X = 7'h58;
  localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
  localparam logic [LETTER_W-1:0] CH_C = 7'h43;
  localparam logic [LETTER_W-1:0] CH_D = 7'h44;
  localparam logic [LETTER_W-1:0] CH_M = 7'h4D;

  // symbol of a decade: one, five or ten
  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_t;

  // decade of a digit position, thousands down to units
  typedef enum logic [1:0] {
    DEC_UNITS = 2'd0,
    DEC_TENS  = 2'd1,
    DEC_HUNDS = 2'd2,
    DEC_THOUS = 2'd3
  } decade_t;

  typedef logic [3:0] digit_t;

  // one classified value: M count plus the three lower digits
  typedef struct packed {
    logic [1:0] thou;
    digit_t     hund;
    digit_t     tens;
    digit_t     units;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:         n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:               n = 3'd2;
      4'd3, 4'd7:         n = 3'd3;
      4'd8:               n = 3'd4;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t digit_sym(input digit_t d, input logic [1:0] pos);
    sym_t s;
    s = SYM_ONE;
    case (d)
      4'd4: if (pos == 2'd1) s = SYM_FIVE;
      4'd5, 4'd6, 4'd7,
      4'd8: if (pos == 2'd0) s = SYM_FIVE;
      4'd9: if (pos == 2'd1) s = SYM_TEN;
      default: s = SYM_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [LETTER_W-1:0] glyph(input decade_t dec, input sym_t s);
    logic [LETTER_W-1:0] g;
    case (dec)
      DEC_UNITS: g = (s == SYM_ONE) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
      DEC_TENS:  g = (s == SYM_ONE) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
      DEC_HUNDS: g = (s == SYM_ONE) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
      default:   g = CH_M;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== sv/binary_to_roman_numeral.sv =====
// ----------------------------------------------------------------------------
// binary_to_roman_numeral
// binary value in, roman numeral out as a run of ascii letter transfers
// ----------------------------------------------------------------------------
// throughput: one input per cycle into the digit pipeline unless a value at its end
//   waits on a full queue; the letter emitter sends one letter per cycle while the
//   output is not stalled, 1 to 15 letters per value; values with no letters are
//   dropped before the queue and never reach the emitter
// reset: synchronous, clears pipeline valids, queue pointers and emitter state
`default_nettype none

module binary_to_roman_numeral #(
  parameter int QUEUE_DEPTH = rtn_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rtn_pkg::S_TDATA_W-1:0]  s_tdata,   // [13:0] value, [15:14] zero
  // output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [rtn_pkg::M_TDATA_W-1:0]       m_tdata,   // [6:0] letter, [7] zero
  output logic                                m_tlast    // final letter of a numeral
);
  import rtn_pkg::*;

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   queue_full;

  // queue to back
  logic   pop;
  entry_t head;
  logic   queue_empty;

  logic [LETTER_W-1:0] letter;

  // digit split: value divided by ten three times, thousands wrapped mod ten,
  // values that give no letters are dropped here
  rtn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  // decouples digit split from the letter emitter
  rtn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  // letter emitter with registered output, m, c, x, i order per decade
  rtn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (queue_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_letter (letter),
    .out_last   (m_tlast)
  );

  // zero pad the letter to a whole byte
  assign m_tdata = {1'b0, letter};

endmodule

`default_nettype wire

// ===== sv/rtn_front.sv =====
// ----------------------------------------------------------------------------
// rtn_front
// digit split pipeline: three divides by ten over four stages, then classification
// ----------------------------------------------------------------------------
`default_nettype none

module rtn_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rtn_pkg::VALUE_W-1:0]  in_value,
  output logic                              push,
  output rtn_pkg::entry_t                   push_entry,
  input  wire logic                         queue_full
);
  import rtn_pkg::*;

  logic        v1, v2, v3, v4;
  logic [13:0] val1;
  logic [10:0] q1_1, q1_2, q1_3;
  logic [7:0]  q2_2, q2_3;
  logic [4:0]  q3_3;
  digit_t      u2, u3, u4, tn3, tn4, h4;
  logic [3:0]  th4;

  logic [28:0] prod1;
  logic [25:0] prod2;
  logic [22:0] prod3;
  logic [13:0] u_diff;
  logic [10:0] tn_diff;
  logic [7:0]  h_diff;
  logic [4:0]  th_wrap;
  logic [1:0]  thou_cnt;
  logic        nonempty;
  logic        en;

  assign prod1   = 29'(in_value) * 29'(DIV10_MUL);
  assign prod2   = 26'(q1_1) * 26'(DIV10_MUL);
  assign prod3   = 23'(q2_2) * 23'(DIV10_MUL);
  assign u_diff  = val1 - (14'({q1_1, 3'b000}) + 14'({q1_1, 1'b0}));
  assign tn_diff = q1_2 - (11'({q2_2, 3'b000}) + 11'({q2_2, 1'b0}));
  assign h_diff  = q2_3 - (8'({q3_3, 3'b000}) + 8'({q3_3, 1'b0}));
  assign th_wrap = (q3_3 >= 5'd10) ? (q3_3 - 5'd10) : q3_3;

  // stage 4 classification: only thousands digits one to three emit M
  assign thou_cnt = (th4 >= 4'd1 && th4 <= 4'd3) ? th4[1:0] : 2'd0;
  assign nonempty = (thou_cnt != 2'd0) || (h4 != 4'd0) || (tn4 != 4'd0) || (u4 != 4'd0);

  assign en       = !(v4 && nonempty && queue_full);
  assign in_ready = en;
  assign push     = v4 && nonempty && en;

  assign push_entry.thou  = thou_cnt;
  assign push_entry.hund  = h4;
  assign push_entry.tens  = tn4;
  assign push_entry.units = u4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1  <= in_value;
      q1_1  <= prod1[DIV10_SHIFT+10:DIV10_SHIFT];
      u2    <= u_diff[3:0];
      q1_2  <= q1_1;
      q2_2  <= prod2[DIV10_SHIFT+7:DIV10_SHIFT];
      u3    <= u2;
      tn3   <= tn_diff[3:0];
      q2_3  <= q2_2;
      q3_3  <= prod3[DIV10_SHIFT+4:DIV10_SHIFT];
      u4    <= u3;
      tn4   <= tn3;
      h4    <= h_diff[3:0];
      th4   <= th_wrap[3:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtn_queue.sv =====
// ----------------------------------------------------------------------------
// rtn_queue
// small fifo of classified values between digit split and letter emitter
// ----------------------------------------------------------------------------
`default_nettype none

module rtn_queue #(
  parameter int DEPTH = rtn_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rtn_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output rtn_pkg::entry_t       head,
  output logic                  empty
);
  import rtn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtn_back.sv =====
// ----------------------------------------------------------------------------
// rtn_back
// letter emitter: walks digit and symbol position, while the output is not stalled one letter per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rtn_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rtn_pkg::entry_t              head,
  input  wire logic                         empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rtn_pkg::LETTER_W-1:0]      out_letter,
  output logic                              out_last
);
  import rtn_pkg::*;

  logic       busy;
  entry_t     cur;
  logic [1:0] idx, pos;

  digit_t     digs  [4];
  logic [2:0] lens  [4];
  logic [2:0] hlens [4];
  logic       slot_free, advance, more_in_digit, nxt_found, cur_last;
  logic [1:0] nxt_idx, first_idx;
  logic [LETTER_W-1:0] cur_letter;
  sym_t       cur_sym;

  assign digs[0] = {2'b00, cur.thou};
  assign digs[1] = cur.hund;
  assign digs[2] = cur.tens;
  assign digs[3] = cur.units;
  assign lens[0] = {1'b0, cur.thou};
  assign lens[1] = digit_len(cur.hund);
  assign lens[2] = digit_len(cur.tens);
  assign lens[3] = digit_len(cur.units);
  assign hlens[0] = {1'b0, head.thou};
  assign hlens[1] = digit_len(head.hund);
  assign hlens[2] = digit_len(head.tens);
  assign hlens[3] = digit_len(head.units);

  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = idx;
    first_idx = 2'd3;
    for (int j = 3; j >= 0; j--) begin
      if (j > int'(idx) && lens[j] != 3'd0) begin
        nxt_found = 1'b1;
        nxt_idx   = 2'(j);
      end
      if (hlens[j] != 3'd0) begin
        first_idx = 2'(j);
      end
    end
  end

  assign more_in_digit = (3'(pos) + 3'd1) < lens[idx];
  assign cur_last      = !more_in_digit && !nxt_found;
  assign cur_sym       = (idx == 2'd0) ? SYM_ONE : digit_sym(digs[idx], pos);
  assign cur_letter    = glyph(decade_t'(2'd3 - idx), cur_sym);

  assign slot_free = !out_valid || out_ready;
  assign advance   = busy && slot_free;
  assign pop       = !empty && (!busy || (advance && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && cur_last) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      idx <= first_idx;
      pos <= 2'd0;
    end else if (advance) begin
      if (more_in_digit) begin
        pos <= pos + 2'd1;
      end else begin
        idx <= nxt_idx;
        pos <= 2'd0;
      end
    end
    if (advance) begin
      out_letter <= cur_letter;
      out_last   <= cur_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (3'(pos) < lens[idx]))
    else $error("symbol position beyond digit length");

  a_mid_stays_busy: assert property (@(posedge clk) disable iff (rst)
    (advance && !cur_last) |=> busy)
    else $error("emitter dropped a numeral before its last letter");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!busy || (advance && cur_last)))
    else $error("queue popped while a numeral is still in flight");

  a_letter_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("letter lost on the way to the output register");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stream test of the binary to roman numeral converter: a short table of
// directed values followed by random values, with random gaps on the input
// side and random stalls on the letter side; every letter transfer is compared
// against typed numerals or a behavioral numeral generator kept in this file
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtn_pkg::*;

  localparam int RANDOM_ITEMS  = 136;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int DIRECTED_ROWS = 24;

  // one expected letter transfer
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } letter_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  letter_t pending_letters[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      rx_hold     = 0;
  int      rx_count    = 0;
  bit      rx_calm     = 1'b0;

  // directed table: numerals are typed in where they are obvious, the rest
  // go through the numeral generator
  logic [VALUE_W-1:0] directed_value [DIRECTED_ROWS] = '{
    14'd0,    14'd1,    14'd3888, 14'd4000, 14'd9999, 14'd16383,
    14'd12345, 14'd10000, 14'd1000, 14'd3000, 14'd4,   14'd5,
    14'd9,    14'd40,   14'd90,   14'd400,  14'd900,  14'd444,
    14'd1994, 14'd2768, 14'd8192, 14'd6000, 14'd7777, 14'd38
  };
  bit directed_typed [DIRECTED_ROWS] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0
  };
  string directed_numeral [DIRECTED_ROWS] = '{
    "", "I", "MMMDCCCLXXXVIII", "", "CMXCIX", "CCCLXXXIII",
    "MMCCCXLV", "", "M", "MMM", "", "",
    "", "", "", "", "", "",
    "", "", "", "", "", ""
  };

  always #4 clk = ~clk;

  binary_to_roman_numeral u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // idle cycles before an item or after a letter; none during a calm stretch
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  // appends the letters of one value to the expected stream, last flag on
  // the final letter; thousands digits above three add nothing
  function automatic void roman_letters_of(input logic [VALUE_W-1:0] value);
    int unsigned         rest;
    int unsigned         digit;
    int unsigned         thou;
    int unsigned         scale;
    logic [LETTER_W-1:0] one_l;
    logic [LETTER_W-1:0] five_l;
    logic [LETTER_W-1:0] ten_l;
    logic [LETTER_W-1:0] seq[$];
    rest  = value;
    thou  = (rest / 1000) % 10;
    scale = 100;
    if (thou >= 1 && thou <= 3) begin
      repeat (thou) seq.push_back(CH_M);
    end
    for (int k = 2; k >= 0; k--) begin
      digit = (rest / scale) % 10;
      scale = scale / 10;
      case (decade_t'(k))
        DEC_HUNDS: begin one_l = CH_C; five_l = CH_D; ten_l = CH_M; end
        DEC_TENS:  begin one_l = CH_X; five_l = CH_L; ten_l = CH_C; end
        default:   begin one_l = CH_I; five_l = CH_V; ten_l = CH_X; end
      endcase
      // subtractive forms for four and nine, else optional five plus ones
      case (digit)
        4: begin
          seq.push_back(one_l);
          seq.push_back(five_l);
        end
        9: begin
          seq.push_back(one_l);
          seq.push_back(ten_l);
        end
        default: begin
          if (digit >= 5) seq.push_back(five_l);
          repeat (digit % 5) seq.push_back(one_l);
        end
      endcase
    end
    foreach (seq[i]) pending_letters.push_back('{seq[i], i == seq.size() - 1});
  endfunction

  // drives one value and returns at the edge where the transfer completes;
  // valid stays high across back-to-back items
  task automatic send_value(input logic [VALUE_W-1:0] value, input bit calm);
    int gap;
    gap = draw_wait(calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-VALUE_W){1'b0}}, value};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [VALUE_W-1:0] value;
    byte                ch;
    int                 n;
    bit                 tx_calm;
    tx_calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table, expectations queued right at the accepting edge
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_value(directed_value[i], tx_calm);
      if (directed_typed[i]) begin
        n = directed_numeral[i].len();
        for (int j = 0; j < n; j++) begin
          ch = directed_numeral[i][j];
          pending_letters.push_back('{ch[LETTER_W-1:0], j == n - 1});
        end
      end else begin
        roman_letters_of(directed_value[i]);
      end
    end

    // random part: mostly ordinary numerals, plus full range, out of range,
    // silent values and long numerals
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        6: value = VALUE_W'($urandom_range(0, 9999));
        7: value = VALUE_W'($urandom_range(10000, 16383));
        8: value = VALUE_W'($urandom_range(0, 1) ? $urandom_range(4, 9) * 1000
                                                 : $urandom_range(0, 1) * 10000);
        9: value = VALUE_W'($urandom_range(1, 3) * 1000 + $urandom_range(6, 8) * 100
                            + $urandom_range(6, 8) * 10 + $urandom_range(6, 8));
        default: value = VALUE_W'($urandom_range(1, 3999));
      endcase
      send_value(value, tx_calm);
      roman_letters_of(value);
    end
    s_tvalid <= 1'b0;

    // drain, then allow time for any stray letter to show up
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // letter side: check each transfer, then draw a stall for the next one
  always @(posedge clk) begin
    letter_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else if (m_tvalid === 1'b1 && m_tready) begin
      if (pending_letters.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected letter transfer: letter 0x%02h last %0b",
                   m_tdata[LETTER_W-1:0], m_tlast);
        end
      end else begin
        want = pending_letters.pop_front();
        if (m_tdata[LETTER_W-1:0] !== want.letter || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("letter mismatch: expected %c (0x%02h) last %0b, got 0x%02h last %0b",
                     want.letter, want.letter, want.last,
                     m_tdata[LETTER_W-1:0], m_tlast);
          end
        end
      end
      if (rx_count % 24 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      rx_count++;
      rx_hold = draw_wait(rx_calm);
      if (rx_hold != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      // stall countdown, ready comes back once it runs out
      if (rx_hold <= 1) m_tready <= 1'b1;
      if (rx_hold > 0) rx_hold--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
